[rtl/core/swaabb_pkg.sv]
// Types, widths and the rational compare shared by the swept box collision pipeline.
`timescale 1ns / 1ps
`default_nettype none
package swaabb_pkg;

    localparam int PW  = 20;          // edge and distance width, signed
    localparam int DW  = 13;          // velocity magnitude width
    localparam int PRW = PW + DW + 1; // cross product width
    localparam int RW  = DW + 1;      // divider remainder width

    localparam int IN_W = 152;

    typedef logic signed [PW-1:0]  pos_t;
    typedef logic [DW-1:0]         den_t;
    typedef logic signed [1:0]     inf_t;
    typedef logic signed [PRW-1:0] prod_t;
    typedef logic signed [1:0]     nrm_t;

    localparam inf_t INF_NEG  = -2'sd1;
    localparam inf_t INF_NONE = 2'sd0;
    localparam inf_t INF_POS  = 2'sd1;

    localparam nrm_t NRM_NEG  = -2'sd1;
    localparam nrm_t NRM_ZERO = 2'sd0;
    localparam nrm_t NRM_POS  = 2'sd1;

    typedef struct packed {
        pos_t num;
        den_t den;
        inf_t inf;
    } qtime_t;

    typedef struct packed {
        logic   broad;
        logic   already;
        qtime_t xe;
        qtime_t xx;
        qtime_t ye;
        qtime_t yx;
        logic   xin_neg;
        logic   yin_neg;
    } s1_t;

    typedef struct packed {
        logic   broad;
        logic   already;
        qtime_t entry;
        qtime_t exitt;
        logic   both_below;
        logic   any_above;
        nrm_t   nh;
        nrm_t   nv;
    } s3_t;

    // -1, 0, 1 as a < b, a == b, a > b; l and r are the cross products
    function automatic logic signed [1:0] qcmp(input inf_t ai, input inf_t bi,
                                               input prod_t l, input prod_t r);
        logic signed [1:0] res;
        if (ai != INF_NONE || bi != INF_NONE)
        begin
            if (ai == bi)
                res = 2'sd0;
            else
                res = (ai < bi) ? -2'sd1 : 2'sd1;
        end
        else
        begin
            if (l < r)
                res = -2'sd1;
            else
                res = (l > r) ? 2'sd1 : 2'sd0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/core/swept_aabb_collision.sv]
// Swept box against static box collision: pipelined entry time and normal.
//
//  channel | dir | fields (tdata, lowest bit first)
//  s_axis  | in  | mover_x, mover_y, mover_width, mover_height, mover_vel_x,
//          |     | mover_vel_y, target_x, target_y, target_width, target_height
//  m_axis  | out | hit_time, normal_horizontal, normal_vertical
//
// One word per cycle while the pipeline is not frozen: four stages of edges,
// cross products and compares, then one restoring divider stage per quotient
// bit, the last of which is the output register.
// m_axis_tready low while m_axis_tvalid is high freezes the whole pipeline; s_axis_tready follows it.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module swept_aabb_collision
    import swaabb_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // mover_x, mover_y, mover_width, mover_height, mover_vel_x, mover_vel_y,
    // target_x, target_y, target_width, target_height, 2 zero bits
    input  wire logic [IN_W-1:0]     s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // hit_time, normal_horizontal, normal_vertical, zero fill
    output logic [((TIME_FRAC_BITS+5+7)/8)*8-1:0] m_axis_tdata
);

    localparam int F    = TIME_FRAC_BITS;
    localparam int OW   = ((F + 5 + 7) / 8) * 8;
    localparam int NDIV = F + 1;

    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // stage 1: edges, broadphase, entry and exit distances
    s1_t  s1_next, s1_reg;
    logic v1_reg;

    always_comb
    begin
        pos_t mx, my, mw, mh, vx, vy, tx, ty, tw, th;
        pos_t ml, mr, mt, mb, tl, tr, tt, tb, bl, br, bt, bb;
        pos_t xin, xout, yin, yout;
        mx = pos_t'($signed(s_axis_tdata[15:0]));
        my = pos_t'($signed(s_axis_tdata[31:16]));
        mw = pos_t'({1'b0, s_axis_tdata[46:32]});
        mh = pos_t'({1'b0, s_axis_tdata[61:47]});
        vx = pos_t'($signed(s_axis_tdata[74:62]));
        vy = pos_t'($signed(s_axis_tdata[87:75]));
        tx = pos_t'($signed(s_axis_tdata[103:88]));
        ty = pos_t'($signed(s_axis_tdata[119:104]));
        tw = pos_t'({1'b0, s_axis_tdata[134:120]});
        th = pos_t'({1'b0, s_axis_tdata[149:135]});
        ml = mx; mr = mx + mw; mt = my; mb = my - mh;
        tl = tx; tr = tx + tw; tt = ty; tb = ty - th;
        bl = (vx > 0) ? ml : ml + vx;
        br = (vx > 0) ? mr + vx : mr;
        bt = (vy > 0) ? mt + vy : mt;
        bb = (vy > 0) ? mb : mb + vy;
        s1_next.broad   = !(br < tl || bl > tr || bb > tt || bt < tb);
        s1_next.already = !(mr < tl || ml > tr || mb > tt || mt < tb);
        if (vx > 0)
        begin
            xin = tl - mr; xout = tr - ml;
        end
        else
        begin
            xin = tr - ml; xout = tl - mr;
        end
        if (vy > 0)
        begin
            yin = tb - mt; yout = tt - mb;
        end
        else
        begin
            yin = tt - mb; yout = tb - mt;
        end
        s1_next.xin_neg = xin < 0;
        s1_next.yin_neg = yin < 0;
        if (vx == 0)
        begin
            s1_next.xe = '{num: '0, den: den_t'(1), inf: INF_NEG};
            s1_next.xx = '{num: '0, den: den_t'(1), inf: INF_POS};
        end
        else if (vx < 0)
        begin
            s1_next.xe = '{num: -xin,  den: den_t'(-vx), inf: INF_NONE};
            s1_next.xx = '{num: -xout, den: den_t'(-vx), inf: INF_NONE};
        end
        else
        begin
            s1_next.xe = '{num: xin,  den: den_t'(vx), inf: INF_NONE};
            s1_next.xx = '{num: xout, den: den_t'(vx), inf: INF_NONE};
        end
        if (vy == 0)
        begin
            s1_next.ye = '{num: '0, den: den_t'(1), inf: INF_NEG};
            s1_next.yx = '{num: '0, den: den_t'(1), inf: INF_POS};
        end
        else if (vy < 0)
        begin
            s1_next.ye = '{num: -yin,  den: den_t'(-vy), inf: INF_NONE};
            s1_next.yx = '{num: -yout, den: den_t'(-vy), inf: INF_NONE};
        end
        else
        begin
            s1_next.ye = '{num: yin,  den: den_t'(vy), inf: INF_NONE};
            s1_next.yx = '{num: yout, den: den_t'(vy), inf: INF_NONE};
        end
    end

    // stage 2: cross products for entry and exit compares
    s1_t   s2_reg;
    prod_t pel_reg, per_reg, pxl_reg, pxr_reg;
    logic  v2_reg;

    // stage 3: pick entry and exit, normal, range checks
    s3_t  s3_next, s3_reg;
    logic v3_reg;

    always_comb
    begin
        logic signed [1:0] ce, cx;
        ce = qcmp(s2_reg.xe.inf, s2_reg.ye.inf, pel_reg, per_reg);
        cx = qcmp(s2_reg.xx.inf, s2_reg.yx.inf, pxl_reg, pxr_reg);
        s3_next.broad      = s2_reg.broad;
        s3_next.already    = s2_reg.already;
        s3_next.entry      = (ce >= 0) ? s2_reg.xe : s2_reg.ye;
        s3_next.exitt      = (cx <= 0) ? s2_reg.xx : s2_reg.yx;
        s3_next.both_below =
            (s2_reg.xe.inf == INF_NEG || (s2_reg.xe.inf == INF_NONE && s2_reg.xe.num < 0)) &&
            (s2_reg.ye.inf == INF_NEG || (s2_reg.ye.inf == INF_NONE && s2_reg.ye.num < 0));
        s3_next.any_above =
            s2_reg.xe.inf == INF_POS ||
            (s2_reg.xe.inf == INF_NONE && s2_reg.xe.num > pos_t'({1'b0, s2_reg.xe.den})) ||
            s2_reg.ye.inf == INF_POS ||
            (s2_reg.ye.inf == INF_NONE && s2_reg.ye.num > pos_t'({1'b0, s2_reg.ye.den}));
        if (ce > 0)
        begin
            s3_next.nh = s2_reg.xin_neg ? NRM_POS : NRM_NEG;
            s3_next.nv = NRM_ZERO;
        end
        else
        begin
            s3_next.nh = NRM_ZERO;
            s3_next.nv = s2_reg.yin_neg ? NRM_POS : NRM_NEG;
        end
    end

    // stage 4: entry against exit cross products
    s3_t   s4_reg;
    prod_t pol_reg, por_reg;
    logic  v4_reg;

    // stage 5: final decision, divider operands
    logic [RW-1:0] d0_num;
    den_t          d0_den;
    nrm_t          d0_nh, d0_nv;

    always_comb
    begin
        logic signed [1:0] co;
        co = qcmp(s4_reg.entry.inf, s4_reg.exitt.inf, pol_reg, por_reg);
        d0_nh = NRM_ZERO;
        d0_nv = NRM_ZERO;
        d0_den = den_t'(1);
        d0_num = '0;
        if (!s4_reg.broad)
        begin
            d0_num = RW'(1);
        end
        else if (s4_reg.already)
        begin
            d0_nv = NRM_POS;
        end
        else if (co > 0 || s4_reg.both_below || s4_reg.any_above)
        begin
            d0_num = RW'(1);
        end
        else
        begin
            d0_nh = s4_reg.nh;
            d0_nv = s4_reg.nv;
            if (s4_reg.entry.inf == INF_NONE && s4_reg.entry.num > 0)
            begin
                d0_num = s4_reg.entry.num[RW-1:0];
                d0_den = s4_reg.entry.den;
            end
        end
    end

    logic [RW-1:0] rem_reg [NDIV];
    logic [F:0]    quo_reg [NDIV];
    den_t          dden_reg [NDIV];
    nrm_t          dnh_reg [NDIV];
    nrm_t          dnv_reg [NDIV];
    logic [NDIV-1:0] dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            dv_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            dv_reg <= {dv_reg[NDIV-2:0], v4_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s1_reg;
            pel_reg <= prod_t'(s1_reg.xe.num) * prod_t'($signed({1'b0, s1_reg.ye.den}));
            per_reg <= prod_t'(s1_reg.ye.num) * prod_t'($signed({1'b0, s1_reg.xe.den}));
            pxl_reg <= prod_t'(s1_reg.xx.num) * prod_t'($signed({1'b0, s1_reg.yx.den}));
            pxr_reg <= prod_t'(s1_reg.yx.num) * prod_t'($signed({1'b0, s1_reg.xx.den}));
            s3_reg  <= s3_next;
            s4_reg  <= s3_reg;
            pol_reg <= prod_t'(s3_reg.entry.num) *
                       prod_t'($signed({1'b0, s3_reg.exitt.den}));
            por_reg <= prod_t'(s3_reg.exitt.num) *
                       prod_t'($signed({1'b0, s3_reg.entry.den}));
        end
    end

    // restoring divider, one quotient bit per stage, top bit first
    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        logic [RW-1:0] r, rem_next;
        logic [F:0]    quo_next;
        logic          qbit;
        den_t          den_in;
        nrm_t          nh_in, nv_in;

        if (k == 0)
        begin : g_first
            assign r        = d0_num;
            assign den_in   = d0_den;
            assign nh_in    = d0_nh;
            assign nv_in    = d0_nv;
            assign quo_next = {{F{1'b0}}, qbit};
        end
        else
        begin : g_rest
            assign r        = {rem_reg[k-1][RW-2:0], 1'b0};
            assign den_in   = dden_reg[k-1];
            assign nh_in    = dnh_reg[k-1];
            assign nv_in    = dnv_reg[k-1];
            assign quo_next = {quo_reg[k-1][F-1:0], qbit};
        end

        assign qbit     = r >= {1'b0, den_in};
        assign rem_next = qbit ? r - {1'b0, den_in} : r;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                dden_reg[k] <= den_in;
                dnh_reg[k]  <= nh_in;
                dnv_reg[k]  <= nv_in;
            end
        end
    end

    assign m_axis_tvalid = dv_reg[NDIV-1];
    assign m_axis_tdata  = OW'({dnv_reg[NDIV-1], dnh_reg[NDIV-1], quo_reg[NDIV-1]});

endmodule
`default_nettype wire

[rtl/core/swaabb_checker.sv]
// Port-level checks for the swept box collision block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module swaabb_checker
    import swaabb_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [((TIME_FRAC_BITS+5+7)/8)*8-1:0] m_axis_tdata
);

    localparam int F = TIME_FRAC_BITS;

    logic [F:0] ht;
    nrm_t       nh, nv;
    assign ht = m_axis_tdata[F:0];
    assign nh = m_axis_tdata[F+2:F+1];
    assign nv = m_axis_tdata[F+4:F+3];

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow the output side");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ht <= (F+1)'(1) << F)
        else $error("hit time above one");

    a_normal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(nh != NRM_ZERO && nv != NRM_ZERO) &&
                          ((nh != NRM_ZERO || nv != NRM_ZERO) || ht == (F+1)'(1) << F))
        else $error("bad normal for hit time");

endmodule

bind swept_aabb_collision swaabb_checker #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_swaabb_checker (.*);
`default_nettype wire
